FILE: hw/rtl/thc_pkg.sv
// Shared types and constants for the torch height control block.
// Holds the configuration, state, request and result structs used by the modules.
// No dependencies.
package thc_pkg;

  localparam int unsigned TICK_US      = 125;
  localparam int unsigned TICKS_PER_MS = 8;
  localparam int unsigned ADC_BITS     = 10;

  localparam int VOLT_W = 10;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 3;

  localparam logic [VOLT_W-1:0] ADC_MASK =
      (ADC_BITS >= VOLT_W) ? {VOLT_W{1'b1}} : VOLT_W'((1 << ADC_BITS) - 1);

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_BAND       = 3'd1,
    REG_FLOOR      = 3'd2,
    REG_SETTLE     = 3'd3,
    REG_STEP_IVL   = 3'd4,
    REG_DIR_INVERT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_setpoint;
    logic [VOLT_W-1:0] band_half_width;
    logic [VOLT_W-1:0] enable_floor;
    logic [15:0]       settle_ms;
    logic [19:0]       step_interval_us;
    logic              dir_invert;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_us;
    logic [31:0]        now_ms;
    logic [3:0]         sub_ms_ticks;
    logic [31:0]        last_step_us;
    logic [31:0]        arc_start_ms;
    logic               raise_flag;
    logic               lower_flag;
    logic signed [31:0] position;
    logic               dir_held;
  } state_t;

  typedef struct packed {
    logic              arc_ok;
    logic [VOLT_W-1:0] arc_voltage;
    logic              in_motion;
  } item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               dir_level;
    logic signed [31:0] z_steps;
    logic               raise_active;
    logic               lower_active;
  } result_t;

endpackage

FILE: hw/rtl/thc_cfg_regs.sv
// Configuration register file for the torch height control block.
// Depends on thc_pkg for the register indexes and the cfg_t struct.
module thc_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [thc_pkg::IDX_W-1:0] cfg_index,
  input  logic [thc_pkg::CFG_W-1:0] cfg_wdata,
  output thc_pkg::cfg_t            cfg
);

  thc_pkg::cfg_t cfg_r;
  thc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        thc_pkg::REG_SETPOINT:   cfg_nxt.voltage_setpoint = cfg_wdata[thc_pkg::VOLT_W-1:0];
        thc_pkg::REG_BAND:       cfg_nxt.band_half_width  = cfg_wdata[thc_pkg::VOLT_W-1:0];
        thc_pkg::REG_FLOOR:      cfg_nxt.enable_floor     = cfg_wdata[thc_pkg::VOLT_W-1:0];
        thc_pkg::REG_SETTLE:     cfg_nxt.settle_ms        = cfg_wdata[15:0];
        thc_pkg::REG_STEP_IVL:   cfg_nxt.step_interval_us = cfg_wdata[19:0];
        thc_pkg::REG_DIR_INVERT: cfg_nxt.dir_invert       = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_setpoint <= '0;
      cfg_r.band_half_width  <= 10'd10;
      cfg_r.enable_floor     <= 10'd30;
      cfg_r.settle_ms        <= 16'd3000;
      cfg_r.step_interval_us <= '0;
      cfg_r.dir_invert       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/thc_tick_logic.sv
// Per-tick update of the height control state: step timing, millisecond
// bookkeeping and arc voltage evaluation. Purely combinational; uses thc_pkg.
module thc_tick_logic (
  input  thc_pkg::cfg_t    cfg,
  input  thc_pkg::state_t  cur,
  input  thc_pkg::item_t   item,
  output thc_pkg::state_t  nxt,
  output thc_pkg::result_t res
);

  always_comb begin
    thc_pkg::state_t   s;
    logic              pulse;
    logic [31:0]       us_gap;
    logic [31:0]       ms_gap;
    logic [thc_pkg::VOLT_W-1:0] volts;
    logic signed [thc_pkg::VOLT_W+1:0] band_lo;
    logic [thc_pkg::VOLT_W:0]   band_hi;
    logic              in_band;

    s       = cur;
    pulse   = 1'b0;
    volts   = item.arc_voltage & thc_pkg::ADC_MASK;
    us_gap  = cur.now_us - cur.last_step_us;
    ms_gap  = cur.now_ms - cur.arc_start_ms;
    band_lo = $signed({2'b00, cfg.voltage_setpoint}) - $signed({2'b00, cfg.band_half_width});
    band_hi = {1'b0, cfg.voltage_setpoint} + {1'b0, cfg.band_half_width};
    in_band = ($signed({2'b00, volts}) > band_lo) && ({1'b0, volts} < band_hi);

    // Step check uses the flags left by the previous tick.
    if (us_gap > {12'd0, cfg.step_interval_us}) begin
      priority if (cur.raise_flag) begin
        s.dir_held = cfg.dir_invert;
        s.position = cur.position + 32'sd1;
        pulse      = 1'b1;
      end else if (cur.lower_flag) begin
        s.dir_held = ~cfg.dir_invert;
        s.position = cur.position - 32'sd1;
        pulse      = 1'b1;
      end else begin
        // With neither flag set the interval restarts without a step.
        pulse      = 1'b0;
      end
      s.last_step_us = cur.now_us;
    end

    if (cur.sub_ms_ticks >= 4'(thc_pkg::TICKS_PER_MS)) begin
      if (item.in_motion) begin
        if (!item.arc_ok) begin
          s.raise_flag   = 1'b0;
          s.lower_flag   = 1'b0;
          s.arc_start_ms = cur.now_ms;
        end else if ((ms_gap > {16'd0, cfg.settle_ms}) &&
                     (cfg.voltage_setpoint > cfg.enable_floor)) begin
          priority if (in_band) begin
            s.raise_flag = 1'b0;
            s.lower_flag = 1'b0;
          end else if (volts > cfg.voltage_setpoint) begin
            s.raise_flag = 1'b0;
            s.lower_flag = 1'b1;
          end else begin
            s.raise_flag = 1'b1;
            s.lower_flag = 1'b0;
          end
        end
      end
      s.sub_ms_ticks = 4'd0;
      s.now_ms       = cur.now_ms + 32'd1;
    end
    s.now_us       = cur.now_us + 32'(thc_pkg::TICK_US);
    s.sub_ms_ticks = s.sub_ms_ticks + 4'd1;

    nxt              = s;
    res.step_pulse   = pulse;
    res.dir_level    = s.dir_held;
    res.z_steps      = s.position;
    res.raise_active = s.raise_flag;
    res.lower_active = s.lower_flag;
  end

endmodule

FILE: hw/rtl/torch_height_control_core.sv
// Top level of the plasma torch height control block.
// Instantiates thc_cfg_regs and thc_tick_logic; uses types from thc_pkg.
//
// Usage: each request on the in_ channel is one 125 us timer tick carrying
// the arc-ok flag, the latest arc voltage sample and the motion flag. For
// every request exactly one result leaves on the out_ channel: the step
// pulse for this tick, the held direction level, the Z position and the
// raise and lower flags after the tick.
// The result is registered: the request waits in the input register, and
// the tick update loads the result register when the request advances,
// where the receiver takes it.
// Throughput is one request per cycle while the receiver keeps taking
// results; the state feedback is a single combinational add-and-compare pass.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more; only then does in_ready drop.
// Reset (rst_n low at a clock edge) clears all timers, the flags, the
// position and both pipeline stages, and loads the register defaults.
// Configuration writes on cfg_ take effect at the next edge and are meant
// to be made while no request is in flight.
module torch_height_control_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_arc_ok,
  input  logic [thc_pkg::VOLT_W-1:0] in_arc_voltage,
  input  logic                      in_in_motion,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_step_pulse,
  output logic                      out_dir_level,
  output logic signed [31:0]        out_z_steps,
  output logic                      out_raise_active,
  output logic                      out_lower_active,
  input  logic                      cfg_we,
  input  logic [thc_pkg::IDX_W-1:0] cfg_index,
  input  logic [thc_pkg::CFG_W-1:0] cfg_wdata
);

  thc_pkg::cfg_t    cfg;
  thc_pkg::state_t  state_r;
  thc_pkg::state_t  state_nxt;
  thc_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  thc_pkg::result_t tick_res;
  thc_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             adv;

  thc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  thc_tick_logic u_tick (
    .cfg  (cfg),
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (tick_res)
  );

  // The held request moves on when the result register is free or emptying.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.arc_ok      <= in_arc_ok;
      s1_item_r.arc_voltage <= in_arc_voltage;
      s1_item_r.in_motion   <= in_in_motion;
    end
  end

  // Tick state advances only together with a result being loaded, so the
  // next request always sees the state its predecessor left behind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= tick_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_pulse   = out_res_r.step_pulse;
  assign out_dir_level    = out_res_r.dir_level;
  assign out_z_steps      = out_res_r.z_steps;
  assign out_raise_active = out_res_r.raise_active;
  assign out_lower_active = out_res_r.lower_active;

  // The raise and lower flags are never both set by the evaluation.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.raise_flag && state_r.lower_flag))
    else $error("raise and lower flags both set");

  // The millisecond tick counter never runs past its wrap point.
  a_sub_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.sub_ms_ticks <= 4'(thc_pkg::TICKS_PER_MS))
    else $error("sub-millisecond tick counter out of range");

  // A step pulse always moves the position.
  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tick_res.step_pulse) |=> (state_r.position != $past(state_r.position)))
    else $error("step pulse without position change");

  // Without an advance the tick state must not change.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("tick state changed without a request");

  // A pending result always mirrors the current state.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.z_steps == state_r.position &&
                     out_res_r.raise_active == state_r.raise_flag &&
                     out_res_r.lower_active == state_r.lower_flag))
    else $error("result register out of step with tick state");

endmodule
